[rtl/core/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, limits and stage payload types for the point-in-polygon
// ray crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int DET_W        = PROD_W + 1;
  localparam int MAX_VERTICES = 1024;
  localparam int CNT_W        = 11;
  localparam int CNT_LIMIT    = (1 << CNT_W) - 1;
  localparam int CNT_MAX      = (MAX_VERTICES > CNT_LIMIT) ? CNT_LIMIT : MAX_VERTICES;
  localparam int IN_W         = 4 * COORD_W;
  localparam int RES_W        = CNT_W + 1;
  localparam int OUT_W        = ((RES_W + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    vertex_t p0;
    vertex_t p1;
  } edge_t;

  typedef struct packed {
    edge_t   e0;
    edge_t   e1;
    vertex_t pt;
    logic    e0_en;
    logic    e1_en;
    logic    start;
    logic    last;
  } edge_pair_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
    logic                     live;
    logic                     flat;
    logic                     down;
  } edge_prod_t;

  typedef struct packed {
    edge_prod_t e0;
    edge_prod_t e1;
    logic       start;
    logic       last;
  } prod_pair_t;

endpackage

[rtl/core/point_in_polygon_crossing.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// A result beat shows on m_axis after the last vertex beat passes the
// three-stage edge pipeline (operand register, product register, count/result
// register). Throughput: one vertex beat per cycle unless m_axis stalls.
// Reset: synchronous rst empties the pipeline and waits for a first vertex.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // vertex_x, vertex_y, point_x, point_y
  input  logic [pip_pkg::IN_W-1:0]  s_axis_tdata,
  // last_vertex
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // inside_res, crossing_count, zero pad
  output logic [pip_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int CW = pip_pkg::COORD_W;

  pip_pkg::vertex_t          in_vtx;
  pip_pkg::vertex_t          in_pt;
  pip_pkg::edge_pair_t       pair;
  pip_pkg::prod_pair_t       prod;
  logic                      pair_valid;
  logic                      pair_ready;
  logic                      prod_valid;
  logic                      prod_ready;
  logic                      res_inside;
  logic [pip_pkg::CNT_W-1:0] res_count;

  assign in_vtx.x = s_axis_tdata[CW-1:0];
  assign in_vtx.y = s_axis_tdata[2*CW-1:CW];
  assign in_pt.x  = s_axis_tdata[3*CW-1:2*CW];
  assign in_pt.y  = s_axis_tdata[4*CW-1:3*CW];

  pip_edge_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_vtx    (in_vtx),
    .in_pt     (in_pt),
    .in_last   (s_axis_tlast),
    .out_valid (pair_valid),
    .out_ready (pair_ready),
    .out_pair  (pair)
  );

  pip_edge_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pair_valid),
    .in_ready  (pair_ready),
    .in_pair   (pair),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_prod  (prod)
  );

  pip_count u_count (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (prod_valid),
    .in_ready   (prod_ready),
    .in_prod    (prod),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_inside (res_inside),
    .res_count  (res_count)
  );

  assign m_axis_tdata = {{(pip_pkg::OUT_W - pip_pkg::RES_W){1'b0}}, res_count, res_inside};

endmodule

[rtl/core/pip_edge_prep.sv]
// ----------------------------------------------------------------------------
// pip_edge_prep
// Tracks the polygon state (query point, first and previous vertex) and
// registers the endpoints of the edges that each vertex beat closes.
// ----------------------------------------------------------------------------
module pip_edge_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pip_pkg::vertex_t    in_vtx,
  input  pip_pkg::vertex_t    in_pt,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output pip_pkg::edge_pair_t out_pair
);

  logic                in_polygon;
  pip_pkg::vertex_t    held_pt;
  pip_pkg::vertex_t    first;
  pip_pkg::vertex_t    prev;
  pip_pkg::vertex_t    pt_sel;
  pip_pkg::vertex_t    first_sel;
  pip_pkg::edge_pair_t pair_next;
  logic                accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pt_sel          = in_polygon ? held_pt : in_pt;
    first_sel       = in_polygon ? first : in_vtx;
    pair_next.e0.p0 = prev;
    pair_next.e0.p1 = in_vtx;
    pair_next.e1.p0 = in_vtx;
    pair_next.e1.p1 = first_sel;
    pair_next.pt    = pt_sel;
    pair_next.e0_en = in_polygon;
    pair_next.e1_en = in_last;
    pair_next.start = !in_polygon;
    pair_next.last  = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_polygon <= 1'b0;
      out_valid  <= 1'b0;
      held_pt    <= '0;
      first      <= '0;
      prev       <= '0;
    end else if (accept) begin
      in_polygon <= !in_last;
      out_valid  <= 1'b1;
      held_pt    <= pt_sel;
      first      <= first_sel;
      prev       <= in_vtx;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pair <= pair_next;
    end
  end

endmodule

[rtl/core/pip_edge_mult.sv]
// ----------------------------------------------------------------------------
// pip_edge_mult
// Per edge: bounding tests against the query point, slope direction and
// the two cross products of the intersection test, all registered.
// ----------------------------------------------------------------------------
module pip_edge_mult (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pip_pkg::edge_pair_t in_pair,
  output logic                out_valid,
  input  logic                out_ready,
  output pip_pkg::prod_pair_t out_prod
);

  function automatic pip_pkg::edge_prod_t edge_prod(pip_pkg::edge_t e, pip_pkg::vertex_t pt,
                                                    logic en);
    logic signed [pip_pkg::DIFF_W-1:0] dx0;
    logic signed [pip_pkg::DIFF_W-1:0] dy0;
    logic signed [pip_pkg::DIFF_W-1:0] dx1;
    logic signed [pip_pkg::DIFF_W-1:0] dy1;
    logic                              skip;
    pip_pkg::edge_prod_t               r;
    dx0 = {e.p0.x[pip_pkg::COORD_W-1], e.p0.x} - {pt.x[pip_pkg::COORD_W-1], pt.x};
    dy0 = {e.p0.y[pip_pkg::COORD_W-1], e.p0.y} - {pt.y[pip_pkg::COORD_W-1], pt.y};
    dx1 = {e.p1.x[pip_pkg::COORD_W-1], e.p1.x} - {pt.x[pip_pkg::COORD_W-1], pt.x};
    dy1 = {e.p1.y[pip_pkg::COORD_W-1], e.p1.y} - {pt.y[pip_pkg::COORD_W-1], pt.y};
    skip = (e.p0.x > pt.x && e.p1.x > pt.x) ||
           (e.p0.y > pt.y && e.p1.y > pt.y) ||
           (e.p0.y < pt.y && e.p1.y < pt.y);
    r.lhs  = dx0 * dy1;
    r.rhs  = dx1 * dy0;
    r.live = en && !skip;
    r.flat = (e.p1.y == e.p0.y);
    r.down = (e.p1.y < e.p0.y);
    return r;
  endfunction

  pip_pkg::prod_pair_t prod_next;
  logic                advance;

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  always_comb begin
    prod_next.e0    = edge_prod(in_pair.e0, in_pair.pt, in_pair.e0_en);
    prod_next.e1    = edge_prod(in_pair.e1, in_pair.pt, in_pair.e1_en);
    prod_next.start = in_pair.start;
    prod_next.last  = in_pair.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_prod <= prod_next;
    end
  end

endmodule

[rtl/core/pip_count.sv]
// ----------------------------------------------------------------------------
// pip_count
// Resolves each edge from the sign of the determinant, keeps the running
// saturating crossing count and parity, and holds the result beat.
// ----------------------------------------------------------------------------
module pip_count (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pip_pkg::prod_pair_t       in_prod,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic                      res_inside,
  output logic [pip_pkg::CNT_W-1:0] res_count
);

  function automatic logic edge_hit(pip_pkg::edge_prod_t p);
    logic signed [pip_pkg::DET_W-1:0] det;
    det = {p.lhs[pip_pkg::PROD_W-1], p.lhs} - {p.rhs[pip_pkg::PROD_W-1], p.rhs};
    return p.live && (p.flat || (det == '0) || (det[pip_pkg::DET_W-1] != p.down));
  endfunction

  logic [pip_pkg::CNT_W-1:0] crossings;
  logic                      parity;
  logic                      hit0;
  logic                      hit1;
  logic [pip_pkg::CNT_W-1:0] base;
  logic [pip_pkg::CNT_W:0]   sum;
  logic [pip_pkg::CNT_W-1:0] crossings_next;
  logic                      parity_next;
  logic                      take;

  assign in_ready = !in_prod.last || !res_valid || res_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    hit0        = edge_hit(in_prod.e0);
    hit1        = edge_hit(in_prod.e1);
    base        = in_prod.start ? '0 : crossings;
    sum         = {1'b0, base} + (pip_pkg::CNT_W+1)'(hit0) + (pip_pkg::CNT_W+1)'(hit1);
    parity_next = (in_prod.start ? 1'b0 : parity) ^ hit0 ^ hit1;
    if (sum > (pip_pkg::CNT_W+1)'(pip_pkg::CNT_MAX)) begin
      crossings_next = pip_pkg::CNT_W'(pip_pkg::CNT_MAX);
    end else begin
      crossings_next = sum[pip_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crossings <= '0;
      parity    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        crossings <= crossings_next;
        parity    <= parity_next;
      end
      if (take && in_prod.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_prod.last) begin
      res_inside <= parity_next;
      res_count  <= crossings_next;
    end
  end

endmodule

[rtl/core/pip_checker.sv]
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks on the result stream of the crossing test.
// ----------------------------------------------------------------------------
module pip_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [pip_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam logic [pip_pkg::CNT_W-1:0] CMAX = pip_pkg::CNT_W'(pip_pkg::CNT_MAX);

  // parity follows the count until it saturates
  a_parity: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[pip_pkg::CNT_W:1] < CMAX) |->
      m_axis_tdata[0] == m_axis_tdata[1])
    else $error("inside flag disagrees with crossing count");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[pip_pkg::CNT_W:1] <= CMAX)
    else $error("crossing count above limit");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[pip_pkg::OUT_W-1:pip_pkg::RES_W] == '0)
    else $error("result pad bits not zero");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind point_in_polygon_crossing pip_checker u_pip_checker (.*);
